/* rtl/vlqd_pkg.sv */
// ----------------------------------------------------------------------------
// vlqd_pkg: shared types and constants for the length-prefix deframer
// Holds register indexes, reset values, status codes and the result item type.
// ----------------------------------------------------------------------------
package vlqd_pkg;

  // Register and field widths
  localparam int REG_W      = 32;
  localparam int BYTE_W     = 8;
  localparam int DIGIT_W    = 7;
  localparam int CONT_POS   = 7;
  localparam int CFG_IDX_W  = 1;

  // Default parameter values
  localparam int MAX_FIELD_BYTES_DEF = 5;
  localparam int LENGTH_BITS_DEF     = 32;

  // Register reset values
  localparam logic [REG_W-1:0] MAX_MSG_SIZE_RST  = 32'd65536;
  localparam logic [REG_W-1:0] DEST_CAPACITY_RST = 32'd65536;

  // Register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_MAX_MSG_SIZE  = 1'd0;
  localparam cfg_idx_t CFG_DEST_CAPACITY = 1'd1;

  // End-of-message status codes
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TOO_SMALL = 2'd1,
    STATUS_DESER_ERR = 2'd2
  } status_t;

  // One result item
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              last;
    status_t           status;
    logic [REG_W-1:0]  msg_length;
  } result_t;

endpackage

/* rtl/vlq_length_prefix_deframer.sv */
// ----------------------------------------------------------------------------
// vlq_length_prefix_deframer: base-128 length-prefixed message deframer
// Splits a received byte stream into messages and passes payload bytes on.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) takes one received byte per
//   item. Each message is a big-endian base-128 length field (bit 7 = more
//   field bytes follow, at most MAX_FIELD_BYTES bytes) then the payload.
//   Output channel (out_valid/out_ready) gives zero or one result per byte:
//   a payload byte (byte_valid), and on the last payload byte also last,
//   status and msg_length. A zero length gives an empty end item at once.
//   A bad length field gives one error item (status deserialize failed) and
//   latches an error; all later bytes are dropped until reset.
//   Each result is registered before it appears on the output.
//   Throughput: one byte per cycle while in_ready is high, set by the
//   single decode stage feeding the result register.
//   Stall: a result register plus a skid register hold up to two results;
//   in_ready drops only while both are full.
//   Reset: rst (synchronous) clears decode state and the sticky error and
//   loads both registers with 65536. The user writes registers through
//   cfg_we/cfg_index/cfg_data only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module vlq_length_prefix_deframer
  import vlqd_pkg::*;
#(
  parameter int MAX_FIELD_BYTES = MAX_FIELD_BYTES_DEF,
  parameter int LENGTH_BITS     = LENGTH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // Configuration
  input  logic              cfg_we,
  input  cfg_idx_t          cfg_index,
  input  logic [REG_W-1:0]  cfg_data,
  // Received bytes
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] rx_byte,
  // Results
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              byte_valid,
  output logic              last,
  output status_t           status,
  output logic [REG_W-1:0]  msg_length
);

  localparam int ACC_W = DIGIT_W * MAX_FIELD_BYTES;
  localparam int CMP_W = (ACC_W > REG_W + 1) ? ACC_W : REG_W + 1;
  localparam int CNT_W = $clog2(MAX_FIELD_BYTES + 1);

  // Configuration registers
  logic [REG_W-1:0] max_msg_size;
  logic [REG_W-1:0] dest_capacity;

  // Decode state
  logic [ACC_W-1:0]       length_acc;
  logic [CNT_W-1:0]       field_cnt;
  logic                   in_payload;
  logic [LENGTH_BITS-1:0] payload_cnt;
  logic [LENGTH_BITS-1:0] cur_length;
  logic                   error_latched;

  logic [ACC_W-1:0]       length_acc_next;
  logic [CNT_W-1:0]       field_cnt_next;
  logic                   in_payload_next;
  logic [LENGTH_BITS-1:0] payload_cnt_next;
  logic [LENGTH_BITS-1:0] cur_length_next;
  logic                   error_latched_next;

  logic             accept;
  logic             has_result;
  result_t          res;
  result_t          out_data;
  logic             can_push;

  logic [ACC_W-1:0]       acc_or;
  logic [CMP_W-1:0]       acc_ext;
  logic [CNT_W-1:0]       field_inc;
  logic                   too_big;
  logic                   deliver;
  logic [LENGTH_BITS-1:0] payload_inc;
  logic                   is_last;

  assign in_ready = can_push;
  assign accept   = in_valid && in_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_msg_size  <= MAX_MSG_SIZE_RST;
      dest_capacity <= DEST_CAPACITY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_MSG_SIZE:  max_msg_size  <= cfg_data;
        CFG_DEST_CAPACITY: dest_capacity <= cfg_data;
        default: ;
      endcase
    end
  end

  // Datapath terms for the length field and the payload
  assign acc_or      = length_acc | ACC_W'(rx_byte[DIGIT_W-1:0]);
  assign acc_ext     = CMP_W'(acc_or);
  assign field_inc   = field_cnt + 1'b1;
  assign too_big     = (acc_ext > CMP_W'(max_msg_size)) || ((acc_ext >> LENGTH_BITS) != '0);
  assign deliver     = REG_W'(payload_cnt) < dest_capacity;
  assign payload_inc = payload_cnt + 1'b1;
  assign is_last     = payload_inc == cur_length;

  // Decode one byte: next state and the result it causes
  always_comb begin
    length_acc_next    = length_acc;
    field_cnt_next     = field_cnt;
    in_payload_next    = in_payload;
    payload_cnt_next   = payload_cnt;
    cur_length_next    = cur_length;
    error_latched_next = error_latched;
    has_result         = 1'b0;
    res                = '0;
    res.status         = STATUS_OK;

    if (error_latched) begin
      // sticky error: drop the byte
    end else if (!in_payload) begin
      if (rx_byte[CONT_POS]) begin
        if (field_inc >= CNT_W'(MAX_FIELD_BYTES)) begin
          // overlong field
          length_acc_next    = '0;
          field_cnt_next     = '0;
          error_latched_next = 1'b1;
          has_result         = 1'b1;
          res.last           = 1'b1;
          res.status         = STATUS_DESER_ERR;
        end else begin
          length_acc_next = acc_or << DIGIT_W;
          field_cnt_next  = field_inc;
        end
      end else begin
        length_acc_next = '0;
        field_cnt_next  = '0;
        if (too_big) begin
          error_latched_next = 1'b1;
          has_result         = 1'b1;
          res.last           = 1'b1;
          res.status         = STATUS_DESER_ERR;
        end else if (acc_or == '0) begin
          // empty message
          has_result = 1'b1;
          res.last   = 1'b1;
        end else begin
          cur_length_next  = acc_ext[LENGTH_BITS-1:0];
          payload_cnt_next = '0;
          in_payload_next  = 1'b1;
        end
      end
    end else begin
      payload_cnt_next = payload_inc;
      if (deliver) begin
        has_result     = 1'b1;
        res.out_byte   = rx_byte;
        res.byte_valid = 1'b1;
      end
      if (is_last) begin
        has_result       = 1'b1;
        res.last         = 1'b1;
        res.msg_length   = REG_W'(cur_length);
        res.status       = (REG_W'(cur_length) > dest_capacity) ? STATUS_TOO_SMALL : STATUS_OK;
        in_payload_next  = 1'b0;
        payload_cnt_next = '0;
        cur_length_next  = '0;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      length_acc    <= '0;
      field_cnt     <= '0;
      in_payload    <= 1'b0;
      payload_cnt   <= '0;
      cur_length    <= '0;
      error_latched <= 1'b0;
    end else if (accept) begin
      length_acc    <= length_acc_next;
      field_cnt     <= field_cnt_next;
      in_payload    <= in_payload_next;
      payload_cnt   <= payload_cnt_next;
      cur_length    <= cur_length_next;
      error_latched <= error_latched_next;
    end
  end

  // Result register and skid stage
  vlqd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && has_result),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_byte   = out_data.out_byte;
  assign byte_valid = out_data.byte_valid;
  assign last       = out_data.last;
  assign status     = out_data.status;
  assign msg_length = out_data.msg_length;

`ifndef SYNTHESIS
  // Once latched, the error holds until reset
  assert property (@(posedge clk) disable iff (rst) error_latched |=> error_latched)
    else $error("error latch cleared without reset");

  // Never reading a payload while the error is latched
  assert property (@(posedge clk) disable iff (rst) !(in_payload && error_latched))
    else $error("payload state active with error latched");

  // Error report carries no byte and no length
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_DESER_ERR) |-> (last && !byte_valid && msg_length == '0))
    else $error("malformed error report");

  // Input backpressure only while a result is pending
  assert property (@(posedge clk) disable iff (rst) !in_ready |-> out_valid)
    else $error("input stalled with empty output");
`endif

endmodule

/* rtl/vlqd_out_buf.sv */
// ----------------------------------------------------------------------------
// vlqd_out_buf: result register with skid stage
// Holds a finished result while the receiver stalls and keeps one more in a
// skid register, so the decoder can take a byte while a result waits.
// ----------------------------------------------------------------------------
module vlqd_out_buf
  import vlqd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    can_push,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;

  // Room for a new result as long as the skid stage is empty
  assign can_push = !skid_valid;

  // Control: output register refills from skid first, then from the decoder
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule
